/* hw/rtl/ale_pkg.sv */
package ale_pkg;

    localparam logic [2:0] REQ_READ    = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_APPEND  = 3'd2;
    localparam logic [2:0] REQ_REMOVE  = 3'd3;
    localparam logic [2:0] REQ_REPLACE = 3'd4;
    localparam logic [2:0] REQ_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [6:0]  location;
        logic [31:0] item;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        match;
        logic [1:0]  status;
        logic [7:0]  count;
        logic        is_empty;
        logic        is_full;
    } rsp_t;

    typedef enum logic [2:0] {
        K_READ,
        K_INSERT,
        K_APPEND,
        K_REMOVE,
        K_REPLACE,
        K_CLEAR,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        loc_in_depth;
        logic [6:0]  location;
        logic [31:0] item;
    } cmd_t;

endpackage

/* hw/rtl/ale_ram.sv */
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_reg;

endmodule

/* hw/rtl/ale_front.sv */
module ale_front #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ale_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output ale_pkg::cmd_t cmd
);

    localparam logic [1:0] QDEPTH = 2'd2;

    ale_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          do_push;
    logic          do_pop;
    ale_pkg::cmd_t cmd_in;

    always_comb
    begin
        cmd_in.location     = req.location;
        cmd_in.item         = req.item;
        cmd_in.loc_in_depth = ({25'd0, req.location} < 32'(DEPTH));
        case (req.req_type)
            ale_pkg::REQ_READ:    cmd_in.kind = ale_pkg::K_READ;
            ale_pkg::REQ_INSERT:  cmd_in.kind = ale_pkg::K_INSERT;
            ale_pkg::REQ_APPEND:  cmd_in.kind = ale_pkg::K_APPEND;
            ale_pkg::REQ_REMOVE:  cmd_in.kind = ale_pkg::K_REMOVE;
            ale_pkg::REQ_REPLACE: cmd_in.kind = ale_pkg::K_REPLACE;
            ale_pkg::REQ_CLEAR:   cmd_in.kind = ale_pkg::K_CLEAR;
            default:              cmd_in.kind = ale_pkg::K_NOP;
        endcase
    end

    assign full      = (fill_reg == QDEPTH);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_ready && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* hw/rtl/ale_back.sv */
module ale_back #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  ale_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          pop,
    output ale_pkg::rsp_t rsp
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = (CW > 7) ? CW : 7;
    localparam int CXW = CW + 8;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_UP     = 5'b00100,
        S_DOWN   = 5'b01000,
        S_FILL   = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         ptr_reg;
    logic [AW-1:0]         ptr_next;
    logic [AW-1:0]         stop_reg;
    logic [AW-1:0]         stop_next;
    logic [DATA_WIDTH-1:0] item_reg;
    logic [DATA_WIDTH-1:0] item_next;
    logic                  res_valid_reg;
    ale_pkg::rsp_t         res_reg;
    ale_pkg::rsp_t         res_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  start;
    logic [XW-1:0]         loc_x;
    logic [XW-1:0]         cnt_x;
    logic [AW-1:0]         loc_a;
    logic [AW-1:0]         cnt_a;
    logic [XW-1:0]         cnt_m2;
    logic                  full_now;
    logic [63:0]           item_ext;
    logic [DATA_WIDTH-1:0] item_d;
    logic [63:0]           rd_ext;
    logic [CXW-1:0]        cnt_wide;

    logic                  fin;
    logic [1:0]            fin_status;
    logic                  fin_read;

    ale_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign start     = (state_reg == S_IDLE) && cmd_valid && (!res_valid_reg || pop);
    assign cmd_ready = start;
    assign loc_x     = XW'(cmd.location);
    assign cnt_x     = XW'(count_reg);
    assign loc_a     = loc_x[AW-1:0];
    assign cnt_a     = cnt_x[AW-1:0];
    assign cnt_m2    = cnt_x - XW'(2);
    assign full_now  = (count_reg == CW'(DEPTH));
    assign item_ext  = 64'(cmd.item);
    assign item_d    = item_ext[DATA_WIDTH-1:0];
    assign rd_ext    = 64'(ram_rdata);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        stop_next  = stop_reg;
        item_next  = item_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        fin        = 1'b0;
        fin_status = ale_pkg::ST_OK;
        fin_read   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item_d;
                    case (cmd.kind)
                        ale_pkg::K_READ:
                        begin
                            if (loc_x >= cnt_x)
                            begin
                                fin        = 1'b1;
                                fin_status = ale_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = loc_a;
                                state_next = S_RDWAIT;
                            end
                        end
                        ale_pkg::K_INSERT:
                        begin
                            if (loc_x > cnt_x || !cmd.loc_in_depth)
                            begin
                                fin        = 1'b1;
                                fin_status = ale_pkg::ST_RANGE;
                            end
                            else if (full_now)
                            begin
                                fin        = 1'b1;
                                fin_status = ale_pkg::ST_FULL;
                            end
                            else if (loc_x == cnt_x)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = loc_a;
                                ram_wdata  = item_d;
                                count_next = count_reg + CW'(1);
                                fin        = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cnt_a - AW'(1);
                                ptr_next   = cnt_a;
                                stop_next  = loc_a;
                                state_next = S_UP;
                            end
                        end
                        ale_pkg::K_APPEND:
                        begin
                            fin = 1'b1;
                            if (full_now)
                            begin
                                fin_status = ale_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = cnt_a;
                                ram_wdata  = item_d;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ale_pkg::K_REMOVE:
                        begin
                            if (loc_x >= cnt_x)
                            begin
                                fin        = 1'b1;
                                fin_status = ale_pkg::ST_RANGE;
                            end
                            else if (loc_x == cnt_x - XW'(1))
                            begin
                                count_next = count_reg - CW'(1);
                                fin        = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = loc_a + AW'(1);
                                ptr_next   = loc_a;
                                stop_next  = cnt_m2[AW-1:0];
                                state_next = S_DOWN;
                            end
                        end
                        ale_pkg::K_REPLACE:
                        begin
                            fin = 1'b1;
                            if (loc_x >= cnt_x)
                            begin
                                fin_status = ale_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = loc_a;
                                ram_wdata = item_d;
                            end
                        end
                        ale_pkg::K_CLEAR:
                        begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                fin        = 1'b1;
                fin_read   = 1'b1;
                state_next = S_IDLE;
            end
            S_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if (ptr_reg - AW'(1) == stop_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    ptr_next  = ptr_reg - AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg - AW'(2);
                end
            end
            S_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = stop_reg;
                ram_wdata  = item_reg;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_DOWN:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if (ptr_reg == stop_reg)
                begin
                    count_next = count_reg - CW'(1);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next  = ptr_reg + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + AW'(2);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_wide = CXW'(count_next);

    always_comb
    begin
        res_next.read_data = fin_read ? rd_ext[31:0] : 32'd0;
        res_next.match     = fin_read && (ram_rdata == item_reg);
        res_next.status    = fin_status;
        res_next.count     = cnt_wide[7:0];
        res_next.is_empty  = (count_next == '0);
        res_next.is_full   = (count_next == CW'(DEPTH));
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        stop_reg <= stop_next;
        item_reg <= item_next;
        if (fin)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fin)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = res_valid_reg;
    assign rsp       = res_reg;

endmodule

/* hw/rtl/array_list_engine.sv */
// Channel   Handshake              Beat
// request   push / full            ale_pkg::req_t (req_type, location, item)
// result    empty / pop            ale_pkg::rsp_t (read_data .. is_full)
//
// A beat is first registered in a two-beat request queue. The engine then finishes
// append, replace, clear, insert at the end and rejected requests straight from idle;
// read passes a read-wait state; any other insert shifts entries up and then writes
// the item; remove shifts any later entries down. Each move uses the single RAM write port.
// Reset clears the count and control only; the entry RAM is not swept.
// The engine holds a new request while a result waits and pop is low.
module array_list_engine #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ale_pkg::req_t req,
    output logic          empty,
    input  logic          pop,
    output ale_pkg::rsp_t rsp
);

    logic          cmd_valid;
    logic          cmd_ready;
    ale_pkg::cmd_t cmd;
    logic          rsp_valid;

    ale_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ale_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .pop       (pop),
        .rsp       (rsp)
    );

    assign empty = !rsp_valid;

endmodule

/* hw/rtl/ale_checker.sv */
module ale_checker #(
    parameter int DEPTH = 128
) (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input ale_pkg::req_t req,
    input logic          empty,
    input logic          pop,
    input ale_pkg::rsp_t rsp
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("result changed while stalled");

    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.match) |-> (rsp.status == ale_pkg::ST_OK))
        else $error("match set on a failed request");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.read_data != 32'd0) |-> (rsp.status == ale_pkg::ST_OK))
        else $error("read data on a failed request");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(rsp.is_empty && rsp.is_full))
        else $error("list both empty and full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && DEPTH < 256) |-> (rsp.is_empty == (rsp.count == 8'd0)))
        else $error("empty flag disagrees with count");

endmodule

bind array_list_engine ale_checker #(
    .DEPTH (DEPTH)
) u_ale_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);

/* test/tb.sv */
module tb;

    localparam int DEPTH = 128;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BEATS = 950;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    typedef enum int {
        GROW,
        SHRINK,
        MIXED
    } sweep_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    ale_pkg::req_t req = '0;
    ale_pkg::rsp_t rsp;

    ale_pkg::req_t pending[$];
    ale_pkg::rsp_t rsp_due[$];

    logic [31:0] list_mem[DEPTH];
    int list_len = 0;
    int gen_len = 0;

    logic [31:0] hot_words[4] = '{32'hA5A5A5A5, 32'h5A5A5A5A, 32'h00000001, 32'h80000000};

    logic req_took = 1'b0;
    logic rsp_took = 1'b0;
    logic hold = 1'b0;
    logic offering;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int n_taken = 0;
    int n_errors = 0;
    int cycles = 0;
    ale_pkg::rsp_t want_rsp;

    array_list_engine #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(32)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .empty(empty),
        .pop(pop),
        .rsp(rsp)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(input string msg);
        if (n_errors < 50)
            $display("tb: mismatch at %0d: %s", cycles, msg);
        n_errors++;
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", fname, got, want));
    endtask

    task automatic add_req(input logic [2:0] op, input logic [6:0] loc, input logic [31:0] val);
        pending.push_back(ale_pkg::req_t'{req_type: op, location: loc, item: val});
        case (op)
            ale_pkg::REQ_INSERT:  if (loc <= gen_len && gen_len < DEPTH) gen_len++;
            ale_pkg::REQ_APPEND:  if (gen_len < DEPTH) gen_len++;
            ale_pkg::REQ_REMOVE:  if (loc < gen_len) gen_len--;
            ale_pkg::REQ_CLEAR:   gen_len = 0;
            default:              ;
        endcase
    endtask

    task automatic apply_to_list(input ale_pkg::req_t r, output ale_pkg::rsp_t res);
        int i;
        int loc;
        res = '0;
        res.status = ale_pkg::ST_OK;
        loc = r.location;
        case (r.req_type)
            ale_pkg::REQ_READ:
                if (loc >= list_len) res.status = ale_pkg::ST_RANGE;
                else
                begin
                    res.read_data = list_mem[loc];
                    res.match = (list_mem[loc] == r.item);
                end
            ale_pkg::REQ_INSERT:
                if (loc > list_len || loc >= DEPTH) res.status = ale_pkg::ST_RANGE;
                else if (list_len >= DEPTH) res.status = ale_pkg::ST_FULL;
                else
                begin
                    for (i = list_len; i > loc; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[loc] = r.item;
                    list_len++;
                end
            ale_pkg::REQ_APPEND:
                if (list_len >= DEPTH) res.status = ale_pkg::ST_FULL;
                else
                begin
                    list_mem[list_len] = r.item;
                    list_len++;
                end
            ale_pkg::REQ_REMOVE:
                if (loc >= list_len) res.status = ale_pkg::ST_RANGE;
                else
                begin
                    for (i = loc; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            ale_pkg::REQ_REPLACE:
                if (loc >= list_len) res.status = ale_pkg::ST_RANGE;
                else list_mem[loc] = r.item;
            ale_pkg::REQ_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.count = 8'(list_len);
        res.is_empty = (list_len == 0);
        res.is_full = (list_len == DEPTH);
    endtask

    initial
    begin : stimulus
        sweep_t mode;
        int n;
        int r;
        int hi;
        int full_hits;
        int mixed_left;
        logic [2:0] op;
        logic [6:0] loc;
        logic [31:0] val;

        add_req(ale_pkg::REQ_READ, 7'd0, 32'h0);
        add_req(ale_pkg::REQ_REMOVE, 7'd0, 32'h0);
        add_req(ale_pkg::REQ_REPLACE, 7'd0, 32'h1);
        add_req(ale_pkg::REQ_INSERT, 7'd1, 32'h2);
        add_req(ale_pkg::REQ_INSERT, 7'd0, 32'hFFFFFFFF);
        add_req(ale_pkg::REQ_APPEND, 7'd127, 32'h0);
        add_req(ale_pkg::REQ_INSERT, 7'd2, 32'h12345678);
        add_req(ale_pkg::REQ_INSERT, 7'd1, 32'hA5A5A5A5);
        add_req(ale_pkg::REQ_READ, 7'd0, 32'hFFFFFFFF);
        add_req(ale_pkg::REQ_READ, 7'd1, 32'h0);
        add_req(ale_pkg::REQ_READ, 7'd3, 32'h12345678);
        add_req(ale_pkg::REQ_READ, 7'd127, 32'h0);
        add_req(ale_pkg::REQ_REPLACE, 7'd3, 32'h5A5A5A5A);
        add_req(ale_pkg::REQ_REPLACE, 7'd4, 32'h5A5A5A5A);
        add_req(ale_pkg::REQ_REMOVE, 7'd0, 32'h0);
        add_req(ale_pkg::REQ_REMOVE, 7'd2, 32'h0);
        add_req(ale_pkg::REQ_READ, 7'd0, 32'hA5A5A5A5);
        add_req(REQ_SPARE_A, 7'd0, 32'hFFFFFFFF);
        add_req(REQ_SPARE_B, 7'd127, 32'h0);
        add_req(ale_pkg::REQ_CLEAR, 7'd127, 32'hFFFFFFFF);
        add_req(ale_pkg::REQ_CLEAR, 7'd0, 32'h0);
        add_req(ale_pkg::REQ_APPEND, 7'd0, 32'h80000000);
        add_req(ale_pkg::REQ_READ, 7'd0, 32'h80000000);

        mode = GROW;
        full_hits = 0;
        mixed_left = 0;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            r = $urandom_range(0, 99);
            case (mode)
                GROW:
                    op = r < 35 ? ale_pkg::REQ_APPEND : r < 65 ? ale_pkg::REQ_INSERT :
                         r < 75 ? ale_pkg::REQ_READ : r < 85 ? ale_pkg::REQ_REPLACE :
                         r < 97 ? ale_pkg::REQ_REMOVE : r < 98 ? REQ_SPARE_A :
                         r < 99 ? REQ_SPARE_B : ale_pkg::REQ_READ;
                SHRINK:
                    op = r < 50 ? ale_pkg::REQ_REMOVE : r < 65 ? ale_pkg::REQ_READ :
                         r < 75 ? ale_pkg::REQ_REPLACE : r < 85 ? ale_pkg::REQ_APPEND :
                         r < 95 ? ale_pkg::REQ_INSERT : r < 97 ? ale_pkg::REQ_CLEAR :
                         r < 98 ? REQ_SPARE_A : REQ_SPARE_B;
                default:
                    op = r < 20 ? ale_pkg::REQ_READ : r < 38 ? ale_pkg::REQ_INSERT :
                         r < 53 ? ale_pkg::REQ_APPEND : r < 71 ? ale_pkg::REQ_REMOVE :
                         r < 89 ? ale_pkg::REQ_REPLACE : r < 94 ? ale_pkg::REQ_CLEAR :
                         r < 97 ? REQ_SPARE_A : REQ_SPARE_B;
            endcase

            hi = gen_len > 127 ? 127 : gen_len;
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if (op == ale_pkg::REQ_INSERT)
                    loc = 7'($urandom_range(0, hi));
                else
                    loc = gen_len > 0 ? 7'($urandom_range(0, gen_len - 1)) : 7'd0;
            end
            else if (r < 90)
                loc = 7'(hi);
            else
                loc = 7'($urandom_range(0, 127));

            r = $urandom_range(0, 99);
            if (r < 15)
                val = 32'h0;
            else if (r < 30)
                val = 32'hFFFFFFFF;
            else if (r < 55)
                val = hot_words[$urandom_range(0, 3)];
            else
                val = $urandom;

            add_req(op, loc, val);

            case (mode)
                GROW:
                    if (gen_len == DEPTH && ++full_hits >= 8)
                    begin
                        full_hits = 0;
                        mode = SHRINK;
                    end
                SHRINK:
                    if (gen_len == 0)
                    begin
                        mixed_left = 60;
                        mode = MIXED;
                    end
                default:
                    if (--mixed_left <= 0)
                        mode = GROW;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            offering = push && !req_took;
            if (req_took)
            begin
                if (tx_calm > 0)
                begin
                    tx_calm--;
                    tx_gap = 0;
                end
                else
                begin
                    tx_gap = idle_len();
                    if (tx_gap == 0 && $urandom_range(0, 39) == 0)
                        tx_calm = $urandom_range(20, 80);
                end
            end
            if (!offering)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending.size() > 0)
                begin
                    req <= pending.pop_front();
                    offering = 1'b1;
                end
            end
            push <= offering;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (rsp_took)
            begin
                if (rx_calm > 0)
                begin
                    rx_calm--;
                    rx_stall = 0;
                end
                else
                begin
                    rx_stall = idle_len();
                    if (rx_stall == 0 && $urandom_range(0, 39) == 0)
                        rx_calm = $urandom_range(20, 80);
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                pop <= 1'b0;
            end
            else
                pop <= !hold;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_took <= push && !full;
            rsp_took <= pop && !empty;
            if (push && !full)
            begin
                apply_to_list(req, want_rsp);
                rsp_due.push_back(want_rsp);
                n_taken++;
            end
            if (pop && !empty)
            begin
                if (rsp_due.size() == 0)
                    flag_error("result beat with nothing pending");
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    check_field("read_data", rsp.read_data, want_rsp.read_data);
                    check_field("match", 32'(rsp.match), 32'(want_rsp.match));
                    check_field("status", 32'(rsp.status), 32'(want_rsp.status));
                    check_field("count", 32'(rsp.count), 32'(want_rsp.count));
                    check_field("is_empty", 32'(rsp.is_empty), 32'(want_rsp.is_empty));
                    check_field("is_full", 32'(rsp.is_full), 32'(want_rsp.is_full));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        wait (n_taken >= 300);
        @(posedge clk);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold = 1'b0;
    end

    initial
    begin
        @(posedge rst_n);
        while (pending.size() > 0 || push || rsp_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && rsp_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
